[rtl/u2mr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package u2mr_pkg;

  localparam int unsigned HighEntries = 128;
  localparam int unsigned PointW      = 21;

  localparam logic [7:0] QMARK   = 8'h3F;
  localparam logic [7:0] LF_BYTE = 8'h0A;
  localparam logic [7:0] CR_BYTE = 8'h0D;

  // Decoder state: code point bits so far and continuation bytes owed
  typedef struct packed {
    logic [PointW-1:0] point;
    logic [1:0]        owed;
  } dec_state_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
  } res_t;

  // Everything one input byte produces
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic [7:0] byte1;
    dec_state_t next;
  } dec_out_t;

  // Code point to upper-half byte, as a constant match
  function automatic logic [7:0] upper_lookup(input logic [15:0] cp);
    logic [7:0] m;
    case (cp)
      16'h00C4: m = 8'h80; 16'h00C5: m = 8'h81; 16'h00C7: m = 8'h82; 16'h00C9: m = 8'h83;
      16'h00D1: m = 8'h84; 16'h00D6: m = 8'h85; 16'h00DC: m = 8'h86; 16'h00E1: m = 8'h87;
      16'h00E0: m = 8'h88; 16'h00E2: m = 8'h89; 16'h00E4: m = 8'h8A; 16'h00E3: m = 8'h8B;
      16'h00E5: m = 8'h8C; 16'h00E7: m = 8'h8D; 16'h00E9: m = 8'h8E; 16'h00E8: m = 8'h8F;
      16'h00EA: m = 8'h90; 16'h00EB: m = 8'h91; 16'h00ED: m = 8'h92; 16'h00EC: m = 8'h93;
      16'h00EE: m = 8'h94; 16'h00EF: m = 8'h95; 16'h00F1: m = 8'h96; 16'h00F3: m = 8'h97;
      16'h00F2: m = 8'h98; 16'h00F4: m = 8'h99; 16'h00F6: m = 8'h9A; 16'h00F5: m = 8'h9B;
      16'h00FA: m = 8'h9C; 16'h00F9: m = 8'h9D; 16'h00FB: m = 8'h9E; 16'h00FC: m = 8'h9F;
      16'h2020: m = 8'hA0; 16'h00B0: m = 8'hA1; 16'h00A2: m = 8'hA2; 16'h00A3: m = 8'hA3;
      16'h00A7: m = 8'hA4; 16'h2022: m = 8'hA5; 16'h00B6: m = 8'hA6; 16'h00DF: m = 8'hA7;
      16'h00AE: m = 8'hA8; 16'h00A9: m = 8'hA9; 16'h2122: m = 8'hAA; 16'h00B4: m = 8'hAB;
      16'h00A8: m = 8'hAC; 16'h2260: m = 8'hAD; 16'h00C6: m = 8'hAE; 16'h00D8: m = 8'hAF;
      16'h221E: m = 8'hB0; 16'h00B1: m = 8'hB1; 16'h2264: m = 8'hB2; 16'h2265: m = 8'hB3;
      16'h00A5: m = 8'hB4; 16'h00B5: m = 8'hB5; 16'h2202: m = 8'hB6; 16'h2211: m = 8'hB7;
      16'h220F: m = 8'hB8; 16'h03C0: m = 8'hB9; 16'h222B: m = 8'hBA; 16'h00AA: m = 8'hBB;
      16'h00BA: m = 8'hBC; 16'h03A9: m = 8'hBD; 16'h00E6: m = 8'hBE; 16'h00F8: m = 8'hBF;
      16'h00BF: m = 8'hC0; 16'h00A1: m = 8'hC1; 16'h00AC: m = 8'hC2; 16'h221A: m = 8'hC3;
      16'h0192: m = 8'hC4; 16'h2248: m = 8'hC5; 16'h2206: m = 8'hC6; 16'h00AB: m = 8'hC7;
      16'h00BB: m = 8'hC8; 16'h2026: m = 8'hC9; 16'h00A0: m = 8'hCA; 16'h00C0: m = 8'hCB;
      16'h00C3: m = 8'hCC; 16'h00D5: m = 8'hCD; 16'h0152: m = 8'hCE; 16'h0153: m = 8'hCF;
      16'h2013: m = 8'hD0; 16'h2014: m = 8'hD1; 16'h201C: m = 8'hD2; 16'h201D: m = 8'hD3;
      16'h2018: m = 8'hD4; 16'h2019: m = 8'hD5; 16'h00F7: m = 8'hD6; 16'h25CA: m = 8'hD7;
      16'h00FF: m = 8'hD8; 16'h0178: m = 8'hD9; 16'h2044: m = 8'hDA; 16'h20AC: m = 8'hDB;
      16'h2039: m = 8'hDC; 16'h203A: m = 8'hDD; 16'hFB01: m = 8'hDE; 16'hFB02: m = 8'hDF;
      16'h2021: m = 8'hE0; 16'h00B7: m = 8'hE1; 16'h201A: m = 8'hE2; 16'h201E: m = 8'hE3;
      16'h2030: m = 8'hE4; 16'h00C2: m = 8'hE5; 16'h00CA: m = 8'hE6; 16'h00C1: m = 8'hE7;
      16'h00CB: m = 8'hE8; 16'h00C8: m = 8'hE9; 16'h00CD: m = 8'hEA; 16'h00CE: m = 8'hEB;
      16'h00CF: m = 8'hEC; 16'h00CC: m = 8'hED; 16'h00D3: m = 8'hEE; 16'h00D4: m = 8'hEF;
      16'hF8FF: m = 8'hF0; 16'h00D2: m = 8'hF1; 16'h00DA: m = 8'hF2; 16'h00DB: m = 8'hF3;
      16'h00D9: m = 8'hF4; 16'h0131: m = 8'hF5; 16'h02C6: m = 8'hF6; 16'h02DC: m = 8'hF7;
      16'h00AF: m = 8'hF8; 16'h02D8: m = 8'hF9; 16'h02D9: m = 8'hFA; 16'h02DA: m = 8'hFB;
      16'h00B8: m = 8'hFC; 16'h02DD: m = 8'hFD; 16'h02DB: m = 8'hFE; 16'h02C7: m = 8'hFF;
      default:  m = QMARK;
    endcase
    return m;
  endfunction

  // Finished code point to output byte
  function automatic logic [7:0] map_point(input logic [PointW-1:0] cp);
    logic [7:0] m;
    if (cp == PointW'(LF_BYTE)) begin
      m = CR_BYTE;
    end else if (cp < PointW'(8'h80)) begin
      m = cp[7:0];
    end else if (cp[PointW-1:16] != '0) begin
      m = QMARK;
    end else begin
      m = upper_lookup(cp[15:0]);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/u2mr_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Byte input channel
interface u2mr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

// Result channel
interface u2mr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;

  modport source (output valid, output out_byte, output run_end, input ready);
  modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

`default_nettype wire

[rtl/u2mr_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

// Per-byte decode step: current state and byte in, results and next state out
module u2mr_decode
  import u2mr_pkg::*;
(
  input  dec_state_t state_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output dec_out_t   dec_o
);

  logic [PointW-1:0] acc;
  logic [1:0]        owed_m1;
  logic              is_cont;
  logic              lead_path;
  logic [7:0]        lead_byte;
  logic              lead_emits;
  dec_state_t        lead_next;

  assign is_cont = (byte_i[7:6] == 2'b10);
  assign acc     = {state_i.point[PointW-7:0], byte_i[5:0]};
  assign owed_m1 = state_i.owed - 2'd1;

  // Lead byte handling, with the state closed on entry
  always_comb begin
    lead_emits = 1'b1;
    lead_byte  = QMARK;
    lead_next  = '0;
    if (byte_i[7] == 1'b0) begin
      lead_byte = map_point(PointW'(byte_i));
    end else if (byte_i[7:5] == 3'b110) begin
      lead_next.point = PointW'(byte_i[4:0]);
      lead_next.owed  = 2'd1;
      lead_emits      = 1'b0;
    end else if (byte_i[7:4] == 4'b1110) begin
      lead_next.point = PointW'(byte_i[3:0]);
      lead_next.owed  = 2'd2;
      lead_emits      = 1'b0;
    end else if (byte_i[7:3] == 5'b11110) begin
      lead_next.point = PointW'(byte_i[2:0]);
      lead_next.owed  = 2'd3;
      lead_emits      = 1'b0;
    end
    // sequence opened on the final byte: flush as '?'
    if (!lead_emits && last_i) begin
      lead_emits = 1'b1;
      lead_byte  = QMARK;
      lead_next  = '0;
    end
  end

  // Combine open-sequence handling with the lead path
  always_comb begin
    dec_o     = '0;
    lead_path = 1'b0;
    if (state_i.owed != 2'd0) begin
      if (is_cont) begin
        if (owed_m1 == 2'd0) begin
          dec_o.count = 2'd1;
          dec_o.byte0 = map_point(acc);
        end else if (last_i) begin
          dec_o.count = 2'd1;
          dec_o.byte0 = QMARK;
        end else begin
          dec_o.next.point = acc;
          dec_o.next.owed  = owed_m1;
        end
      end else begin
        // broken sequence: '?' then the byte again as a lead
        dec_o.count = 2'd1;
        dec_o.byte0 = QMARK;
        lead_path   = 1'b1;
      end
    end else begin
      lead_path = 1'b1;
    end

    if (lead_path) begin
      dec_o.next = lead_next;
      if (lead_emits) begin
        if (dec_o.count == 2'd0) begin
          dec_o.count = 2'd1;
          dec_o.byte0 = lead_byte;
        end else begin
          dec_o.count = 2'd2;
          dec_o.byte1 = lead_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/utf8_to_mac_roman_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none

// Streaming UTF-8 to 8-bit Roman code page decoder. One byte is taken per
// cycle on in_i while the result queue has room, and yields zero, one or
// two result transactions on out_o; run_end marks the last result of each
// input byte. The path is an input register, a combinational decode and
// table match, and a two-entry result queue. Throughput is one byte per
// cycle while out_o is ready and each byte gives at most one result. A
// byte that gives two (a broken sequence followed by a new lead) leaves
// one extra result in the queue, so the next byte that gives two is held
// in the input register until the queue has room for both. Malformed,
// truncated or unmapped input gives '?' (0x3F); LF becomes CR.
module utf8_to_mac_roman_decoder
  import u2mr_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  u2mr_in_if.sink     in_i,
  u2mr_out_if.source  out_o
);

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // Decoder state
  dec_state_t state_q;
  dec_out_t   dec;

  // Result queue
  res_t       slot0_q, slot0_d;
  res_t       slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d;

  logic       pop;
  logic [1:0] base;
  logic       adv;
  logic       in_take;

  u2mr_decode u_decode (
    .state_i (state_q),
    .byte_i  (s1_byte_q),
    .last_i  (s1_last_q),
    .dec_o   (dec)
  );

  // Handshake and queue space
  assign pop     = out_o.valid & out_o.ready;
  assign base    = cnt_q - {1'b0, pop};
  assign adv     = s1_valid_q & (dec.count <= (2'd2 - base));
  assign in_take = in_i.valid & in_i.ready;

  assign in_i.ready     = ~s1_valid_q | adv;
  assign out_o.valid    = (cnt_q != 2'd0);
  assign out_o.out_byte = slot0_q.out_byte;
  assign out_o.run_end  = slot0_q.run_end;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_i.in_byte;
      s1_last_q <= in_i.is_last;
    end
  end

  // Decoder state advances with each consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (adv) begin
      state_q <= dec.next;
    end
  end

  // Queue update: shift on pop, then append this byte's results
  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop) begin
      slot0_d = slot1_q;
    end
    cnt_d = base;
    if (adv) begin
      cnt_d = base + dec.count;
      if (base == 2'd0) begin
        slot0_d = '{out_byte: dec.byte0, run_end: (dec.count == 2'd1)};
        slot1_d = '{out_byte: dec.byte1, run_end: 1'b1};
      end else if (base == 2'd1) begin
        // one queued: single result goes behind it; a full queue takes only empty bytes
        slot1_d = '{out_byte: dec.byte0, run_end: 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue overfilled");

  a_pair_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.run_end) |-> (cnt_q == 2'd2))
    else $error("non-final result without its partner queued");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_last_q) |=> (state_q.owed == 2'd0))
    else $error("sequence left open after final byte");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_byte_q) && $stable(state_q)))
    else $error("stalled byte or state changed");

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import u2mr_pkg::*;

  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomItems = 1200;
  localparam int unsigned HoldStart   = 300;
  localparam int unsigned HoldLen     = 150;

  // One byte of the input stream
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  // Code points of the upper half: byte 0x80+k stands for point k of this list
  localparam logic [15:0] UpperPoints [HighEntries] = '{
    16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
    16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
    16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
    16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
    16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
    16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
    16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
    16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
    16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
    16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
    16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
    16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
    16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
    16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
    16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
    16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
  };

  logic clk_i;
  logic rst_ni;

  u2mr_in_if  in_bus ();
  u2mr_out_if out_bus ();

  utf8_to_mac_roman_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  byte_item_t        pending_bytes[$];
  res_t              decoded_q[$];
  logic [7:0]        step_bytes[$];
  logic [7:0]        str_bytes[$];

  // Decoder state as predicted
  logic [PointW-1:0] seq_point;
  logic [1:0]        seq_owed;

  byte_item_t        cur_item;
  int                gap_left;
  int                rwait;
  int                in_accepted;
  int                out_accepted;
  int                total_items;
  int                err_count;
  logic              in_burst;
  logic              out_burst;
  logic              hold_off;
  int                hold_cycles;
  bit                hold_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Append one predicted output byte for the current input byte
  task automatic add_step(input logic [7:0] b);
    step_bytes = {step_bytes, b};
  endtask

  // Append one byte to the string being built
  task automatic add_str(input logic [7:0] b);
    str_bytes = {str_bytes, b};
  endtask

  // Finished code point to output byte
  function automatic logic [7:0] roman_byte(input logic [PointW-1:0] cp);
    logic [7:0] m;
    m = QMARK;
    if (cp == PointW'(LF_BYTE)) begin
      m = CR_BYTE;
    end else if (cp < PointW'(8'h80)) begin
      m = cp[7:0];
    end else begin
      for (int k = 0; k < HighEntries; k++) begin
        if (cp == PointW'(UpperPoints[k])) m = 8'h80 + k[7:0];
      end
    end
    return m;
  endfunction

  // Byte taken as a lead; no sequence open on entry
  task automatic lead_byte(input logic [7:0] b, input logic last);
    if (b < 8'h80) begin
      add_step(roman_byte(PointW'(b)));
    end else if (b[7:5] == 3'b110) begin
      seq_point = PointW'(b[4:0]);
      seq_owed  = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      seq_point = PointW'(b[3:0]);
      seq_owed  = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      seq_point = PointW'(b[2:0]);
      seq_owed  = 2'd3;
    end else begin
      add_step(QMARK);
    end
    // lead on the final byte leaves a truncated sequence
    if (seq_owed != 2'd0 && last) begin
      add_step(QMARK);
      seq_owed  = 2'd0;
      seq_point = '0;
    end
  endtask

  // Predict the results of one accepted byte
  task automatic decode_byte(input byte_item_t it);
    res_t r;
    step_bytes.delete();
    if (seq_owed != 2'd0) begin
      if (it.data[7:6] == 2'b10) begin
        seq_point = {seq_point[PointW-7:0], it.data[5:0]};
        seq_owed  = seq_owed - 2'd1;
        if (seq_owed == 2'd0) begin
          add_step(roman_byte(seq_point));
          seq_point = '0;
        end else if (it.last) begin
          add_step(QMARK);
          seq_owed  = 2'd0;
          seq_point = '0;
        end
      end else begin
        // broken sequence: flag it, then retry the byte as a lead
        add_step(QMARK);
        seq_owed  = 2'd0;
        seq_point = '0;
        lead_byte(it.data, it.last);
      end
    end else begin
      lead_byte(it.data, it.last);
    end
    foreach (step_bytes[i]) begin
      r.out_byte = step_bytes[i];
      r.run_end  = (i == step_bytes.size() - 1);
      decoded_q  = {decoded_q, r};
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    byte_item_t it;
    it.data = b;
    it.last = last;
    pending_bytes = {pending_bytes, it};
  endtask

  // UTF-8 encoding of a point at a given length, without range checks
  task automatic encode_point(input logic [PointW-1:0] cp, input int len);
    case (len)
      1: add_str({1'b0, cp[6:0]});
      2: begin
        add_str({3'b110, cp[10:6]});
        add_str({2'b10, cp[5:0]});
      end
      3: begin
        add_str({4'b1110, cp[15:12]});
        add_str({2'b10, cp[11:6]});
        add_str({2'b10, cp[5:0]});
      end
      default: begin
        add_str({5'b11110, cp[20:18]});
        add_str({2'b10, cp[17:12]});
        add_str({2'b10, cp[11:6]});
        add_str({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Input driver: one transaction per item, random gap after each
  always @(posedge clk_i) begin
    logic nv;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        decode_byte(cur_item);
        in_accepted++;
        if (in_accepted % 64 == 0) in_burst = ($urandom_range(0, 3) == 0);
        gap_left = in_burst ? 0 : $urandom_range(0, 6);
      end
      if (!in_bus.valid || in_bus.ready) begin
        nv = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_bytes.size() != 0) begin
          cur_item = pending_bytes.pop_front();
          nv       = 1'b1;
          in_bus.in_byte <= cur_item.data;
          in_bus.is_last <= cur_item.last;
        end
        in_bus.valid <= nv;
      end
    end
  end

  // Result monitor and ready pattern
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_byte %h run_end %b", out_bus.out_byte,
                 out_bus.run_end);
          err_count++;
        end else begin
          want = decoded_q.pop_front();
          if (out_bus.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_bus.out_byte);
            err_count++;
          end
          if (out_bus.run_end !== want.run_end) begin
            $error("run_end: expected %b, got %b", want.run_end, out_bus.run_end);
            err_count++;
          end
        end
        out_accepted++;
        if (out_accepted % 64 == 0) out_burst = ($urandom_range(0, 3) == 0);
        rwait = out_burst ? 0 : $urandom_range(0, 6);
      end
      if (rwait != 0) begin
        rwait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !hold_off;
      end
    end
  end

  // One long receiver hold-off so the block backs up into its input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && !hold_off && in_accepted >= HoldStart) begin
        hold_cycles = 0;
        hold_off <= 1'b1;
      end else if (hold_off) begin
        hold_cycles++;
        if (hold_cycles >= HoldLen) begin
          hold_done = 1'b1;
          hold_off <= 1'b0;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  initial begin
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle = 0;
      else idle++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin
    int                nchar;
    int                kind;
    int                len;
    int                drop;
    int                directed;
    logic [PointW-1:0] cp;

    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.in_byte = '0;
    in_bus.is_last = 1'b0;
    out_bus.ready  = 1'b0;
    hold_off       = 1'b0;
    hold_done      = 1'b0;
    hold_cycles    = 0;
    seq_point      = '0;
    seq_owed       = 2'd0;
    gap_left       = 0;
    rwait          = 0;
    in_accepted    = 0;
    out_accepted   = 0;
    err_count      = 0;
    in_burst       = 1'b0;
    out_burst      = 1'b0;

    // ASCII extremes and LF to CR
    push_byte(8'h00, 1'b0);
    push_byte(8'h0A, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h7F, 1'b1);
    // two-byte mapped and unmapped
    push_byte(8'hC3, 1'b0);
    push_byte(8'h84, 1'b0);
    push_byte(8'hC2, 1'b0);
    push_byte(8'h80, 1'b0);
    // three-byte euro sign
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'hAC, 1'b0);
    // four-byte, largest point
    push_byte(8'hF7, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b0);
    // stray continuation and invalid leads
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hF8, 1'b0);
    // broken sequence retried as ASCII, then as a new lead
    push_byte(8'hC3, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b0);
    push_byte(8'hAC, 1'b0);
    // truncation on the final byte, mid sequence and at the lead
    push_byte(8'hE2, 1'b0);
    push_byte(8'h82, 1'b1);
    push_byte(8'hC3, 1'b1);
    directed = pending_bytes.size();

    // Random strings: mostly well-formed characters, some broken, some noise
    while (pending_bytes.size() < directed + RandomItems) begin
      nchar = $urandom_range(1, 8);
      str_bytes.delete();
      repeat (nchar) begin
        kind = $urandom_range(0, 15);
        if (kind <= 4) begin
          cp = ($urandom_range(0, 7) == 0) ? PointW'(LF_BYTE) : PointW'($urandom_range(0, 127));
          encode_point(cp, 1);
        end else if (kind <= 8) begin
          cp = PointW'(UpperPoints[$urandom_range(0, HighEntries - 1)]);
          encode_point(cp, (cp < PointW'(16'h0800)) ? 2 : 3);
        end else if (kind <= 11) begin
          len = $urandom_range(2, 4);
          encode_point(PointW'($urandom), len);
        end else if (kind <= 13) begin
          len  = $urandom_range(2, 4);
          encode_point(PointW'($urandom), len);
          drop = $urandom_range(1, len - 1);
          repeat (drop) void'(str_bytes.pop_back());
        end else begin
          add_str(8'($urandom_range(0, 255)));
        end
      end
      foreach (str_bytes[i]) begin
        push_byte(str_bytes[i], (i == str_bytes.size() - 1) || ($urandom_range(0, 31) == 0));
      end
    end
    total_items = pending_bytes.size();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // All input accepted, all results drained, then a short quiet period
    while (in_accepted != total_items || decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (decoded_q.size() != 0) begin
      $error("%0d expected results never arrived", decoded_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/u2mr_pkg.sv
rtl/u2mr_if.sv
rtl/u2mr_decode.sv
rtl/utf8_to_mac_roman_decoder.sv
verif/tb.sv
